/* rtl/aes_pkg.sv */
// AES-128 package: payload types, state enum, S-box and round helpers
package aes_pkg;

	typedef struct packed {
		logic [63:0] plain_hi;
		logic [63:0] plain_lo;
	} in_item_t;

	typedef struct packed {
		logic [63:0] cipher_hi;
		logic [63:0] cipher_lo;
	} out_item_t;

	typedef struct packed {
		logic        index;
		logic [63:0] data;
	} cfg_item_t;

	localparam int unsigned REG_KEY_HI = 0;
	localparam int unsigned REG_KEY_LO = 1;
	localparam int unsigned CFG_IDX_W = 8;

	typedef enum logic [2:0] {
		ST_EXPAND,
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} state_t;

	localparam logic [7:0] RCON_FIRST = 8'h01;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the block sits at bits 127-8i
	function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic logic [127:0] next_key(input logic [127:0] p, input logic [7:0] rc);
		logic [31:0]  t;
		logic [127:0] k;
		t = {SBOX[byte_at(p, 13)] ^ rc, SBOX[byte_at(p, 14)],
			SBOX[byte_at(p, 15)], SBOX[byte_at(p, 12)]};
		k[127:96] = p[127:96] ^ t;
		k[95:64]  = p[95:64] ^ k[127:96];
		k[63:32]  = p[63:32] ^ k[95:64];
		k[31:0]   = p[31:0] ^ k[63:32];
		return k;
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8*(r + 4*c) -: 8] = SBOX[byte_at(s, r + 4*((c + r) & 3))];
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_at(s, 4*c);
			a1 = byte_at(s, 4*c + 1);
			a2 = byte_at(s, 4*c + 2);
			a3 = byte_at(s, 4*c + 3);
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
				a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
		end
		return t;
	endfunction

endpackage

/* rtl/aes_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read
module aes_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 11
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* rtl/aes128_block_encrypt.sv */
// AES-128 block encryption top level: key schedule in RAM, one round per cycle
// channel | signals                          | direction
// in      | in_valid, in_ready, in_data      | block in
// out     | out_valid, out_ready, out_data   | block out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | key write
// After transfer a block passes through ST_LOAD, which adds round key 0, then
// ST_RUN per round, each round key read from the key RAM in the state before.
// After reset and after each key write the schedule is rebuilt into the key
// RAM; no block is taken meanwhile.
// A new block is taken only once the previous result has been transferred.
module aes128_block_encrypt #(
	parameter int ROUNDS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  aes_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output aes_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data
);
	localparam int DEPTH = ROUNDS + 1;
	localparam int AW = $clog2(DEPTH);

	aes_pkg::state_t state_q, state_d;
	logic [63:0]  key_hi_q, key_lo_q;
	logic [127:0] kexp_q;
	logic [7:0]   rcon_q;
	logic [AW-1:0] cnt_q;
	logic [127:0] st_q;
	logic         wr_en;
	logic [127:0] wr_data;
	logic [AW-1:0] rd_addr;
	logic [127:0] rk;
	logic [127:0] nk;
	logic [127:0] ss;

	assign nk = aes_pkg::next_key(kexp_q, rcon_q);
	assign wr_en = (state_q == aes_pkg::ST_EXPAND);
	assign wr_data = kexp_q;

	aes_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_keys (
		.clk(clk), .wr_en(wr_en), .wr_addr(cnt_q), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rk)
	);

	assign cfg_ready = (state_q == aes_pkg::ST_IDLE);
	assign in_ready  = (state_q == aes_pkg::ST_IDLE) && !cfg_valid;
	assign out_valid = (state_q == aes_pkg::ST_DONE);
	assign out_data  = {st_q[127:64], st_q[63:0]};
	assign ss = aes_pkg::sub_shift(st_q);

	always_comb begin
		state_d = state_q;
		rd_addr = cnt_q;
		unique case (state_q)
			aes_pkg::ST_EXPAND: if (cnt_q == AW'(ROUNDS)) state_d = aes_pkg::ST_IDLE;
			aes_pkg::ST_IDLE: begin
				rd_addr = '0;
				if (cfg_valid) begin
					if (cfg_index == aes_pkg::CFG_IDX_W'(aes_pkg::REG_KEY_HI) ||
						cfg_index == aes_pkg::CFG_IDX_W'(aes_pkg::REG_KEY_LO))
						state_d = aes_pkg::ST_EXPAND;
				end else if (in_valid)
					state_d = aes_pkg::ST_LOAD;
			end
			aes_pkg::ST_LOAD: begin
				rd_addr = AW'(1);
				state_d = aes_pkg::ST_RUN;
			end
			aes_pkg::ST_RUN: begin
				rd_addr = cnt_q + AW'(1);
				if (cnt_q == AW'(ROUNDS)) state_d = aes_pkg::ST_DONE;
			end
			aes_pkg::ST_DONE: if (out_ready) state_d = aes_pkg::ST_IDLE;
			default: state_d = aes_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= aes_pkg::ST_EXPAND;
			key_hi_q <= '0;
			key_lo_q <= '0;
			kexp_q   <= '0;
			rcon_q   <= aes_pkg::RCON_FIRST;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				aes_pkg::ST_EXPAND: begin
					kexp_q <= nk;
					rcon_q <= aes_pkg::xtime(rcon_q);
					cnt_q  <= cnt_q + AW'(1);
				end
				aes_pkg::ST_IDLE: begin
					cnt_q  <= '0;
					rcon_q <= aes_pkg::RCON_FIRST;
					if (cfg_valid) begin
						if (cfg_index == aes_pkg::CFG_IDX_W'(aes_pkg::REG_KEY_HI)) begin
							key_hi_q <= cfg_data;
							kexp_q   <= {cfg_data, key_lo_q};
						end else if (cfg_index == aes_pkg::CFG_IDX_W'(aes_pkg::REG_KEY_LO)) begin
							key_lo_q <= cfg_data;
							kexp_q   <= {key_hi_q, cfg_data};
						end
					end
				end
				aes_pkg::ST_LOAD: cnt_q <= AW'(1);
				aes_pkg::ST_RUN:  cnt_q <= cnt_q + AW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			aes_pkg::ST_IDLE: if (in_valid && in_ready) st_q <= in_data;
			aes_pkg::ST_LOAD: st_q <= st_q ^ rk;
			aes_pkg::ST_RUN:
				if (cnt_q == AW'(ROUNDS)) st_q <= ss ^ rk;
				else st_q <= aes_pkg::mix_columns(ss) ^ rk;
			default: ;
		endcase
	end
endmodule

/* rtl/aes_checker.sv */
// Port-level checker for the AES-128 block and its bind
module aes_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_valid,
	input logic cfg_ready,
	input aes_pkg::out_item_t out_data
);
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	ap_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("block taken while result pending");
	ap_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result appeared too early");
	ap_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !(in_valid && in_ready))
		else $error("key write and block transfer in one cycle");
endmodule

bind aes128_block_encrypt aes_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready), .out_data(out_data)
);
